// File: hw/rtl/lcg_uniform_normal_dropout_generator_core_defines.svh
// Assertion macros shared by the generator core.
`ifndef LCG_UNIFORM_NORMAL_DROPOUT_GENERATOR_CORE_DEFINES_SVH
`define LCG_UNIFORM_NORMAL_DROPOUT_GENERATOR_CORE_DEFINES_SVH

// Check an implication on every rising edge, skipped while in reset.
`define LUND_ASSERT_IMP(label, lhs, rhs, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
    else $error(msg);

// Check an implication in the cycle after the antecedent.
`define LUND_ASSERT_NXT(label, lhs, rhs, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
    else $error(msg);

`endif

// File: hw/rtl/lund_pkg.sv
`timescale 1ns / 1ps
package lund_pkg;

  localparam int NORMAL_FRAC_BITS = 20;
  localparam int CORDIC_STEPS     = 24;
  localparam int LOG_STEPS        = 24;
  localparam int SQRT_STEPS       = 32;
  localparam int QDEPTH           = 2;

  localparam logic [30:0] LCG_MUL    = 31'd1103515245;
  localparam logic [30:0] LCG_ADD    = 31'd12345;
  localparam logic [30:0] SEED_RST   = 31'h12345678;
  localparam logic [30:0] THRESH_RST = 31'd1073741823;
  localparam logic [23:0] SCALE_RST  = 24'd131072;
  localparam logic [30:0] TWO_LN2_Q30 = 31'd1488522236;
  localparam logic [29:0] GAIN_Q30    = 30'd652032874;
  localparam logic [31:0] T_FLOOR_Q24 = 32'd772619349;

  typedef enum logic [1:0] {
    MODE_UNIFORM = 2'd0,
    MODE_NORMAL  = 2'd1,
    MODE_DROPOUT = 2'd2,
    MODE_NONE    = 2'd3
  } mode_t;

  localparam logic [1:0] REG_SEED   = 2'd0;
  localparam logic [1:0] REG_THRESH = 2'd1;
  localparam logic [1:0] REG_SCALE  = 2'd2;

  // Classified job handed from front to back.
  typedef struct packed {
    mode_t       mode;
    logic        want_second;
    logic [31:0] element_value;
    logic [30:0] d1;
    logic [30:0] d2;
  } job_t;

  typedef struct packed {
    logic [31:0] value;
    logic        keep;
    logic        sat;
    logic        last;
  } res_t;

  function automatic logic [31:0] atan_turn(input logic [4:0] i);
    logic [31:0] v;
    case (i)
      5'd0: v = 32'd536870912;  5'd1: v = 32'd316933406;
      5'd2: v = 32'd167458907;  5'd3: v = 32'd85004756;
      5'd4: v = 32'd42667331;   5'd5: v = 32'd21354465;
      5'd6: v = 32'd10679838;   5'd7: v = 32'd5340245;
      5'd8: v = 32'd2670163;    5'd9: v = 32'd1335087;
      5'd10: v = 32'd667544;    5'd11: v = 32'd333772;
      5'd12: v = 32'd166886;    5'd13: v = 32'd83443;
      5'd14: v = 32'd41721;     5'd15: v = 32'd20860;
      5'd16: v = 32'd10430;     5'd17: v = 32'd5215;
      5'd18: v = 32'd2607;      5'd19: v = 32'd1303;
      5'd20: v = 32'd651;       5'd21: v = 32'd325;
      5'd22: v = 32'd162;       5'd23: v = 32'd81;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage

// File: hw/rtl/lund_front.sv
`timescale 1ns / 1ps
module lund_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_mode,
  input  logic               in_second,
  input  logic [31:0]        in_elem,
  input  logic               seed_we,
  input  logic [30:0]        seed_val,
  output logic               job_valid,
  input  logic               job_ready,
  output lund_pkg::job_t     job
);
  import lund_pkg::*;

  typedef enum logic [1:0] {F_IDLE, F_DRAW2, F_PUSH} fstate_t;

  fstate_t     state_r;
  logic [30:0] gen_r;
  job_t        job_r;
  logic [61:0] prod;
  logic [30:0] step_val;

  // One generator advance: low 31 bits of s*a+c.
  assign prod     = 62'(gen_r) * 62'(LCG_MUL);
  assign step_val = prod[30:0] + LCG_ADD;

  assign in_ready  = (state_r == F_IDLE) && !seed_we;
  assign job_valid = (state_r == F_PUSH);
  assign job       = job_r;

  // Draw one value per word (two for normal mode) and hand the job on; a none-mode word is dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
      gen_r   <= SEED_RST;
    end else if (seed_we) begin
      gen_r <= seed_val;
    end else begin
      case (state_r)
        F_IDLE: begin
          if (in_valid) begin
            job_r.mode          <= mode_t'(in_mode);
            job_r.want_second   <= in_second;
            job_r.element_value <= in_elem;
            if (mode_t'(in_mode) != MODE_NONE) begin
              gen_r    <= step_val;
              job_r.d1 <= step_val;
              state_r  <= (mode_t'(in_mode) == MODE_NORMAL) ? F_DRAW2 : F_PUSH;
            end
          end
        end
        F_DRAW2: begin
          gen_r    <= step_val;
          job_r.d2 <= step_val;
          state_r  <= F_PUSH;
        end
        F_PUSH: if (job_ready) state_r <= F_IDLE;
        default: state_r <= F_IDLE;
      endcase
    end
  end
endmodule

// File: hw/rtl/lund_queue.sv
`timescale 1ns / 1ps
module lund_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           wr_valid,
  output logic           wr_ready,
  input  lund_pkg::job_t wr_job,
  output logic           rd_valid,
  input  logic           rd_ready,
  output lund_pkg::job_t rd_job
);
  import lund_pkg::*;

  job_t mem_r [QDEPTH];
  logic wp_r, rp_r;
  logic [1:0] cnt_r;

  assign wr_ready = (cnt_r != 2'(QDEPTH));
  assign rd_valid = (cnt_r != 2'd0);
  assign rd_job   = mem_r[rp_r];

  // Store and release jobs in order.
  always_ff @(posedge clk) begin
    if (wr_valid && wr_ready) mem_r[wp_r] <= wr_job;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= 2'd0;
    end else begin
      if (wr_valid && wr_ready) wp_r <= ~wp_r;
      if (rd_valid && rd_ready) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(wr_valid && wr_ready) - 2'(rd_valid && rd_ready);
    end
  end
endmodule

// File: hw/rtl/lund_back.sv
`timescale 1ns / 1ps
module lund_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           job_valid,
  output logic           job_ready,
  input  lund_pkg::job_t job,
  input  logic [30:0]    keep_threshold,
  input  logic [23:0]    dropout_scale,
  output logic           res_valid,
  input  logic           res_ready,
  output lund_pkg::res_t res
);
  import lund_pkg::*;

  typedef enum logic [3:0] {
    B_IDLE, B_DROP, B_LNORM, B_LOG, B_LMUL, B_SQRT, B_GAIN, B_CORD,
    B_OUT1, B_OUT2, B_EMIT
  } bstate_t;

  bstate_t     state_r;
  job_t        j_r;
  res_t        res_r;
  logic        pend2_r;
  logic [31:0] y_out_r;
  logic [5:0]  cnt_r;
  logic [31:0] m_r;
  logic [23:0] frac_r;
  logic [4:0]  e_r;
  logic [63:0] acc_r;    // multiply result / sqrt remainder
  logic [63:0] sq_res_r;
  logic [63:0] sq_bit_r;
  logic signed [33:0] x_r, y_r, z_r;
  logic [55:0] dprod_r;

  // Combinational helpers.
  logic [63:0] msq;
  logic [4:0]  top;
  logic [32:0] xg;
  logic [31:0] at;
  logic signed [33:0] dx, dy;
  logic [31:0] a_w;
  logic        flip;
  logic signed [56:0] p_w;
  logic signed [40:0] ps;
  logic [63:0] sum_w;
  logic signed [55:0] dprod_w;
  logic [28:0] lval;
  logic [59:0] lprod;

  assign msq = 64'(m_r) * 64'(m_r);
  always_comb begin
    top = 5'd0;
    for (int i = 0; i < 31; i++) if (j_r.d1[i]) top = 5'(i);
  end
  assign at = atan_turn(cnt_r[4:0]);
  assign dx = y_r >>> cnt_r[4:0];
  assign dy = x_r >>> cnt_r[4:0];
  assign a_w  = {j_r.d2, 1'b0};
  assign flip = a_w[31] ^ a_w[30];
  assign xg   = acc_r[60:28];
  assign sum_w = sq_res_r + sq_bit_r;

  // -log2(u1) in Q5.24 times 2 ln 2 in Q1.30.
  assign lval  = (29'(5'd31 - e_r) << 24) - 29'(frac_r);
  assign lprod = 60'(lval) * 60'(TWO_LN2_Q30);

  // Signed element times unsigned Q8.16 scale, full width.
  assign dprod_w = $signed(job.element_value) * $signed({1'b0, dropout_scale});

  // Round Q30 to output fraction bits and clamp.
  function automatic logic [31:0] to_out(input logic signed [33:0] v);
    logic signed [34:0] t;
    t = (35'(v) + 35'(35'sd1 <<< (29 - NORMAL_FRAC_BITS))) >>> (30 - NORMAL_FRAC_BITS);
    if (t > 35'sd2147483647) return 32'h7FFFFFFF;
    if (t < -35'sd2147483648) return 32'h80000000;
    return t[31:0];
  endfunction

  // Dropout product rounded to Q16.16.
  assign p_w = $signed(dprod_r) + 57'sd32768;
  assign ps  = 41'(p_w >>> 16);

  assign job_ready = (state_r == B_IDLE);
  assign res_valid = (state_r == B_EMIT);
  assign res       = res_r;

  // Sequence one job through the shared units and emit its results.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
      pend2_r <= 1'b0;
    end else begin
      case (state_r)
        B_IDLE: if (job_valid) begin
          j_r <= job;
          case (job.mode)
            MODE_UNIFORM: begin
              res_r   <= '{value: {1'b0, job.d1}, keep: 1'b0, sat: 1'b0, last: 1'b1};
              state_r <= B_EMIT;
            end
            MODE_NORMAL:  state_r <= B_LNORM;
            MODE_DROPOUT: begin
              dprod_r <= dprod_w;
              state_r <= B_DROP;
            end
            default: state_r <= B_IDLE;
          endcase
        end
        B_DROP: begin
          res_r.last <= 1'b1;
          if (j_r.d1 < keep_threshold) begin
            res_r.keep <= 1'b1;
            if (ps > 41'sd2147483647) begin
              res_r.value <= 32'h7FFFFFFF; res_r.sat <= 1'b1;
            end else if (ps < -41'sd2147483648) begin
              res_r.value <= 32'h80000000; res_r.sat <= 1'b1;
            end else begin
              res_r.value <= ps[31:0]; res_r.sat <= 1'b0;
            end
          end else begin
            res_r.value <= 32'd0; res_r.keep <= 1'b0; res_r.sat <= 1'b0;
          end
          state_r <= B_EMIT;
        end
        B_LNORM: begin
          e_r    <= top;
          m_r    <= 32'({j_r.d1, 1'b0} << (5'd30 - top)) >> 1;
          frac_r <= '0;
          cnt_r  <= '0;
          state_r <= (j_r.d1 == 31'd0) ? B_SQRT : B_LOG;
          acc_r  <= {T_FLOOR_Q24, 32'd0};
          sq_res_r <= '0;
          sq_bit_r <= 64'd1 << 62;
        end
        // One squaring step per cycle.
        B_LOG: begin
          if (msq[61]) begin
            m_r <= msq[62:31];
            frac_r[5'd23 - cnt_r[4:0]] <= 1'b1;
          end else begin
            m_r <= msq[61:30];
          end
          cnt_r <= cnt_r + 6'd1;
          if (cnt_r == 6'(LOG_STEPS - 1)) state_r <= B_LMUL;
        end
        B_LMUL: begin
          acc_r <= {2'b00, lprod[59:30], 32'd0};
          state_r <= B_SQRT;
          cnt_r <= '0;
        end
        // One root bit per cycle.
        B_SQRT: begin
          if (acc_r >= sum_w) begin
            acc_r    <= acc_r - sum_w;
            sq_res_r <= (sq_res_r >> 1) + sq_bit_r;
          end else begin
            sq_res_r <= sq_res_r >> 1;
          end
          sq_bit_r <= sq_bit_r >> 2;
          cnt_r <= cnt_r + 6'd1;
          if (cnt_r == 6'(SQRT_STEPS - 1)) state_r <= B_GAIN;
        end
        B_GAIN: begin
          acc_r <= sq_res_r[31:0] * 64'(GAIN_Q30);
          state_r <= B_CORD;
          cnt_r <= 6'd63;
        end
        B_CORD: begin
          if (cnt_r == 6'd63) begin
            x_r <= flip ? -$signed({1'b0, xg}) : $signed({1'b0, xg});
            y_r <= '0;
            z_r <= 34'($signed(flip ? a_w + 32'h80000000 : a_w));
            cnt_r <= '0;
          end else begin
            if (!z_r[33]) begin
              x_r <= x_r - dx; y_r <= y_r + dy; z_r <= z_r - 34'(at);
            end else begin
              x_r <= x_r + dx; y_r <= y_r - dy; z_r <= z_r + 34'(at);
            end
            cnt_r <= cnt_r + 6'd1;
            if (cnt_r == 6'(CORDIC_STEPS - 1)) state_r <= B_OUT1;
          end
        end
        B_OUT1: begin
          res_r   <= '{value: to_out(x_r), keep: 1'b0, sat: 1'b0,
                       last: !j_r.want_second};
          y_out_r <= to_out(y_r);
          pend2_r <= j_r.want_second;
          state_r <= B_EMIT;
        end
        B_OUT2: begin
          res_r   <= '{value: y_out_r, keep: 1'b0, sat: 1'b0, last: 1'b1};
          pend2_r <= 1'b0;
          state_r <= B_EMIT;
        end
        B_EMIT: if (res_ready) state_r <= pend2_r ? B_OUT2 : B_IDLE;
        default: state_r <= B_IDLE;
      endcase
    end
  end
endmodule

// File: hw/rtl/lcg_uniform_normal_dropout_generator_core.sv
`timescale 1ns / 1ps
// Random source: uniform Q0.31 draws, Box-Muller normal pairs in Q11.20 and
// dropout of Q16.16 elements. A front stage advances the 31-bit generator one
// step per word (two for a normal pair) and queues up to two jobs; a back
// stage runs them one at a time. Uniform and dropout items need no iterative
// unit; a normal item runs through the bit-serial 24-step log, 32-step square
// root and 24-step CORDIC in the back stage. Write config only while idle;
// seed writes take priority over input.
module lcg_uniform_normal_dropout_generator_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // [1:0] mode, [2] want_second, [34:3] element_value
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] result_value
  output logic [1:0]  out_tuser,  // [0] keep_mask, [1] saturated
  output logic        out_tlast,  // last_of_run
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [30:0] cfg_data
);
  import lund_pkg::*;
  `include "lcg_uniform_normal_dropout_generator_core_defines.svh"

  logic [30:0] thresh_r;
  logic [23:0] scale_r;
  logic        seed_we;
  logic        fj_valid, fj_ready, bj_valid, bj_ready;
  job_t        fj, bj;
  res_t        res;

  assign cfg_ready = 1'b1;
  assign seed_we   = cfg_valid && (cfg_index == REG_SEED);

  // Hold the config registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thresh_r <= THRESH_RST;
      scale_r  <= SCALE_RST;
    end else if (cfg_valid) begin
      if (cfg_index == REG_THRESH) thresh_r <= cfg_data;
      if (cfg_index == REG_SCALE)  scale_r  <= cfg_data[23:0];
    end
  end

  lund_front u_front (
    .clk, .rst_n, .in_valid(in_tvalid), .in_ready(in_tready),
    .in_mode(in_tdata[1:0]), .in_second(in_tdata[2]), .in_elem(in_tdata[34:3]),
    .seed_we, .seed_val(cfg_data), .job_valid(fj_valid), .job_ready(fj_ready), .job(fj)
  );

  lund_queue u_queue (
    .clk, .rst_n, .wr_valid(fj_valid), .wr_ready(fj_ready), .wr_job(fj),
    .rd_valid(bj_valid), .rd_ready(bj_ready), .rd_job(bj)
  );

  lund_back u_back (
    .clk, .rst_n, .job_valid(bj_valid), .job_ready(bj_ready), .job(bj),
    .keep_threshold(thresh_r), .dropout_scale(scale_r),
    .res_valid(out_tvalid), .res_ready(out_tready), .res
  );

  assign out_tdata = res.value;
  assign out_tuser = {res.sat, res.keep};
  assign out_tlast = res.last;

  `LUND_ASSERT_IMP(a_sat_kept, out_tvalid && out_tuser[1], out_tuser[0], "saturated but dropped")
  `LUND_ASSERT_NXT(a_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata),
                   "result changed while stalled")
  `LUND_ASSERT_IMP(a_sat_limit, out_tvalid && out_tuser[1],
                   (out_tdata == 32'h7FFFFFFF) || (out_tdata == 32'h80000000),
                   "saturated value not at a limit")
endmodule
